// ----- rtl/text_screen_character_writer_assert.svh -----
// Assertion macros for the text screen character writer checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TEXT_SCREEN_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_SCREEN_CHARACTER_WRITER_ASSERT_SVH

`define TSCW_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("text screen writer check failed");

`define TSCW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("text screen writer check failed");

`endif

// ----- rtl/tscw_pkg.sv -----
// Package for the text screen character writer: sequencer states, character
// codes and the character folding function. No dependencies.
`timescale 1ns / 1ps

package tscw_pkg;

  localparam int LINE_CELLS = 32;
  localparam int LINE_BITS  = 5;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CODE_INVERSE   = 8'd1;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_LF        = 8'd10;
  localparam logic [7:0] CODE_CR        = 8'd13;
  localparam logic [7:0] SPACE_CODE     = 8'd32;
  localparam logic [7:0] LOWER_FIRST    = 8'd96;
  localparam logic [7:0] LOWER_LAST     = 8'd126;
  localparam logic [7:0] LOWER_SHIFT    = 8'd32;
  localparam logic [7:0] CURSOR_MARK    = 8'hEF;
  localparam logic [7:0] INVERSE_BIT    = 8'h40;
  localparam logic [7:0] SIX_BITS       = 8'h3F;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_REQ,
    S_RD_DATA,
    S_PUT,
    S_LINE,
    S_BACK,
    S_TOG_RD,
    S_TOG_WR,
    S_COPY,
    S_FILL,
    S_MARK,
    S_RESP
  } state_t;

  function automatic logic [7:0] fold_char(input logic [7:0] code);
    logic [7:0] folded;
    folded = code;
    if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
      folded = code - LOWER_SHIFT;
    end
    return folded & SIX_BITS;
  endfunction

endpackage

// ----- rtl/tscw_cmd_if.sv -----
// Command channel of the text screen character writer.
// Carries the command, character code and read address; no dependencies.
`timescale 1ns / 1ps

interface tscw_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;
  logic [8:0] read_addr;

  modport source (output valid, command, char_code, read_addr, input ready);
  modport sink (input valid, command, char_code, read_addr, output ready);
endinterface

// ----- rtl/tscw_rsp_if.sv -----
// Response channel of the text screen character writer.
// Carries the cursor position and read data; no dependencies.
`timescale 1ns / 1ps

interface tscw_rsp_if;
  logic       valid;
  logic       ready;
  logic [8:0] cursor_pos;
  logic [7:0] read_data;

  modport source (output valid, cursor_pos, read_data, input ready);
  modport sink (input valid, cursor_pos, read_data, output ready);
endinterface

// ----- rtl/tscw_screen_ram.sv -----
// Screen cell store: one write port and one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module tscw_screen_ram #(
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/text_screen_character_writer.sv -----
// Channel | Dir | Payload                              | Transaction
// cmd     | in  | command, char_code, read_addr        | valid and ready high
// rsp     | out | cursor_pos, read_data                | valid and ready high
//
// A read passes S_RD_REQ, S_RD_DATA and S_RESP, and a printable character S_PUT, S_MARK and
// S_RESP unless it scrolls; rsp.valid rises in the same cycle in which cmd.ready is high again.
// A line end writes one space per cycle up to the end of the line.
// A scroll walks the store: it copies every cell up by one line, then clears the last line.
// After reset the store is cleared to spaces while cmd.ready is low.
// A stalled response waits in its register; the next command is taken meanwhile.
// Depends on tscw_pkg, tscw_cmd_if, tscw_rsp_if and tscw_screen_ram.
`timescale 1ns / 1ps

module text_screen_character_writer #(
  parameter int SCREEN_CELLS = 512
) (
  input logic       clk,
  input logic       rst,
  tscw_cmd_if.sink  cmd,
  tscw_rsp_if.source rsp
);

  import tscw_pkg::*;

  localparam int AW = $clog2(SCREEN_CELLS);
  localparam int CW = AW + 1;
  localparam int XW = (CW > 9) ? CW : 9;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] cursor, cursor_next;
  logic [7:0]    result_data, result_data_next;
  logic          out_valid, out_valid_next;
  logic [8:0]    out_cursor;
  logic [7:0]    out_data;
  logic          out_load;

  logic [7:0]    code_q;
  logic [8:0]    addr_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [CW-1:0] cursor_inc;
  logic          wrap;
  logic          addr_in_range;
  logic          accept;

  tscw_screen_ram #(
    .DEPTH(SCREEN_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cursor_inc    = {1'b0, cursor} + CW'(1);
  assign wrap          = (cursor_inc == CW'(SCREEN_CELLS));
  assign addr_in_range = (XW'(addr_q) < XW'(SCREEN_CELLS));
  assign accept        = cmd.valid && cmd.ready;

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.cursor_pos = out_cursor;
  assign rsp.read_data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      count       <= '0;
      cursor      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      cursor      <= cursor_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result_data <= result_data_next;
    if (accept) begin
      code_q <= cmd.char_code;
      addr_q <= cmd.read_addr;
    end
    if (out_load) begin
      out_cursor <= 9'(cursor);
      out_data   <= result_data;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    cursor_next      = cursor;
    result_data_next = result_data;
    out_load         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = cursor;
    ram_wdata        = CURSOR_MARK;
    ram_raddr        = '0;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = count[AW-1:0];
        ram_wdata = SPACE_CODE;
        if (count == CW'(SCREEN_CELLS - 1)) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          count_next = count + CW'(1);
        end
      end
      S_IDLE: begin
        if (cmd.valid) begin
          result_data_next = '0;
          if (cmd.command == CMD_READ) begin
            state_next = S_RD_REQ;
          end else if (cmd.char_code == CODE_CR || cmd.char_code == CODE_LF) begin
            state_next = S_LINE;
          end else if (cmd.char_code == CODE_BACKSPACE) begin
            state_next = (cursor == '0) ? S_MARK : S_BACK;
          end else if (cmd.char_code == CODE_INVERSE) begin
            state_next = (cursor == '0) ? S_MARK : S_TOG_RD;
          end else if (cmd.char_code < SPACE_CODE || cmd.char_code[7]) begin
            state_next = S_RESP;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_RD_REQ: begin
        ram_raddr  = AW'(addr_q);
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        result_data_next = addr_in_range ? ram_rdata : 8'd0;
        state_next       = S_RESP;
      end
      S_PUT, S_LINE: begin
        ram_we    = 1'b1;
        ram_wdata = (state == S_PUT) ? fold_char(code_q) : fold_char(SPACE_CODE);
        if (wrap) begin
          count_next = CW'(LINE_CELLS);
          state_next = S_COPY;
        end else begin
          cursor_next = cursor_inc[AW-1:0];
          if (state == S_PUT || cursor_inc[LINE_BITS-1:0] == '0) begin
            state_next = S_MARK;
          end
        end
      end
      S_BACK: begin
        ram_we      = 1'b1;
        ram_wdata   = SPACE_CODE;
        cursor_next = cursor - AW'(1);
        state_next  = S_MARK;
      end
      S_TOG_RD: begin
        ram_raddr  = cursor - AW'(1);
        state_next = S_TOG_WR;
      end
      S_TOG_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = cursor - AW'(1);
        ram_wdata  = ram_rdata ^ INVERSE_BIT;
        state_next = S_MARK;
      end
      S_COPY: begin
        ram_raddr = count[AW-1:0];
        ram_waddr = AW'(count - CW'(LINE_CELLS + 1));
        ram_wdata = ram_rdata;
        ram_we    = (count > CW'(LINE_CELLS));
        if (count == CW'(SCREEN_CELLS)) begin
          count_next = CW'(SCREEN_CELLS - LINE_CELLS);
          state_next = S_FILL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = count[AW-1:0];
        ram_wdata = SPACE_CODE;
        if (count == CW'(SCREEN_CELLS - 1)) begin
          count_next  = '0;
          cursor_next = AW'(SCREEN_CELLS - LINE_CELLS);
          state_next  = S_MARK;
        end else begin
          count_next = count + CW'(1);
        end
      end
      S_MARK: begin
        ram_we     = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !rsp.ready);
  end

endmodule

// ----- rtl/tscw_checker.sv -----
// Port-level checks for the text screen character writer, bound to its top level.
// Depends on text_screen_character_writer_assert.svh.
`timescale 1ns / 1ps

`include "text_screen_character_writer_assert.svh"

module tscw_checker #(
  parameter int SCREEN_CELLS = 512
) (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [8:0] cursor_pos
);

  localparam int XW = ($clog2(SCREEN_CELLS) + 1 > 9) ? $clog2(SCREEN_CELLS) + 1 : 9;

  // A taken command keeps the writer busy for at least the next cycle.
  `TSCW_ASSERT_NEXT(a_busy_after_take, cmd_valid && cmd_ready, !cmd_ready)

  // A response that is not taken stays offered.
  `TSCW_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

  // A fresh response follows a busy cycle of the command side.
  `TSCW_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), !$past(cmd_ready))

  // The reported cursor always lies inside the screen.
  `TSCW_ASSERT_SAME(a_cursor_range, rsp_valid, XW'(cursor_pos) < XW'(SCREEN_CELLS))

endmodule

bind text_screen_character_writer tscw_checker #(
  .SCREEN_CELLS(SCREEN_CELLS)
) u_tscw_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cursor_pos (rsp.cursor_pos)
);
